// ===== rtl/banded_triangular_solve_macros.svh =====
// assertion macros for the banded triangular solve block
// expects clk_i and rst_ni in the scope of each use
`ifndef BANDED_TRIANGULAR_SOLVE_MACROS_SVH
`define BANDED_TRIANGULAR_SOLVE_MACROS_SVH

// same-cycle implication, disabled in reset
`define BTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define BTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bts_pkg.sv =====
// shared types and constants for the banded triangular solve block
// no dependencies
package bts_pkg;

  localparam int DEF_MAX_ORDER = 64;
  localparam int DEF_MAX_BAND  = 8;
  localparam int DEF_FRAC_BITS = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [1:0] {
    CMD_BAND   = 2'd0,
    CMD_VECTOR = 2'd1,
    CMD_SOLVE  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER = 3'd0,
    REG_TRANS = 3'd1,
    REG_UNIT  = 3'd2,
    REG_ORDER = 3'd3,
    REG_BAND  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_JRD,
    S_JCHK,
    S_DIV,
    S_LRD,
    S_LMUL,
    S_LSUB,
    S_JNEXT,
    S_ORD,
    S_OLD,
    S_OWAIT
  } state_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         band_row;
    logic [5:0]         column;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] solution;
    logic [5:0]         index;
    logic               last;
    logic               divide_by_zero;
  } out_beat_t;

endpackage

// ===== rtl/banded_triangular_solve.sv =====
// top level of the banded triangular solve: band and vector memories,
// solve sequencer, multiply-subtract path; uses bts_pkg, bts_div, macros
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i/in_stall_o   | bts_pkg::in_beat_t
//  out     | output    | out_valid_o/out_stall_i | bts_pkg::out_beat_t
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// band and vector load beats are accepted back to back while the block is idle.
// a solve reads each element (a plain solve skips a zero), divides by the diagonal
// unless unit and does a read, multiply and subtract per band entry it touches.
// one read port per store; results go out one beat at a time, held until taken.
// in_stall_o stays high from a nonzero-order solve until its last beat is taken.
// no clearing pass after reset: both stores are undefined until written.
`include "banded_triangular_solve_macros.svh"

module banded_triangular_solve #(
  parameter int MAX_ORDER = bts_pkg::DEF_MAX_ORDER,
  parameter int MAX_BAND  = bts_pkg::DEF_MAX_BAND,
  parameter int FRAC_BITS = bts_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bts_pkg::in_beat_t               in_beat_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bts_pkg::out_beat_t              out_beat_o,
  input  logic                            cfg_we_i,
  input  logic [bts_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bts_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bts_pkg::*;

  localparam int IW   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int NW   = $clog2(MAX_ORDER + 1);
  localparam int KW   = (MAX_BAND > 0) ? $clog2(MAX_BAND + 1) : 1;
  localparam int BDEP = (MAX_BAND + 1) * MAX_ORDER;
  localparam int BAW  = (BDEP > 1) ? $clog2(BDEP) : 1;

  // configuration
  logic       up_q, tr_q, unit_q;
  logic [6:0] order_q;
  logic [3:0] bw_q;

  state_e state_q, state_d;

  logic [NW-1:0]      n_q, s_q, o_q;
  logic [KW-1:0]      k_q, d_q;
  logic [IW-1:0]      j_q;
  logic signed [31:0] t_q, diag_q, acc_q;
  logic signed [63:0] prod_q;
  logic [MAX_ORDER-1:0] dz_q;
  logic               out_valid_q;
  out_beat_t          out_q;

  // memories
  logic signed [31:0] vec_mem [MAX_ORDER];
  logic signed [31:0] band_mem [BDEP];
  logic signed [31:0] vec_rd_q, band_rd_q;

  logic               vec_re, vec_we, band_re, band_we;
  logic [IW-1:0]      vec_raddr, vec_waddr;
  logic signed [31:0] vec_wdata;
  logic [BAW-1:0]     band_raddr, band_waddr;

  logic               div_start, div_busy, div_done, div_dz;
  logic signed [31:0] div_num, div_den, div_quo;

  logic               in_acc, solve_go, out_take;
  logic [NW-1:0]      n_cfg;
  logic [KW-1:0]      k_cfg;
  logic               down;
  logic [IW-1:0]      j_c, i_c;
  logic [KW-1:0]      dmax_c, r_c, diag_row;
  logic [31:0]        rest;
  logic signed [31:0] opa, sub_res;
  logic signed [64:0] diff;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign solve_go = in_acc && (in_beat_i.command == CMD_SOLVE);
  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q    <= 1'b1;
      tr_q    <= 1'b0;
      unit_q  <= 1'b0;
      order_q <= '0;
      bw_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_UPPER: up_q    <= cfg_data_i[0];
        REG_TRANS: tr_q    <= cfg_data_i[0];
        REG_UNIT:  unit_q  <= cfg_data_i[0];
        REG_ORDER: order_q <= cfg_data_i;
        REG_BAND:  bw_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign n_cfg = (32'(order_q) > MAX_ORDER) ? NW'(MAX_ORDER) : NW'(order_q);
  assign k_cfg = (32'(bw_q) > MAX_BAND) ? KW'(MAX_BAND) : KW'(bw_q);

  // element order and band geometry
  assign down     = tr_q ? !up_q : up_q;
  assign j_c      = down ? IW'(32'(n_q) - 32'd1 - 32'(s_q)) : IW'(s_q);
  assign rest     = 32'(n_q) - 32'd1 - 32'(j_c);
  assign diag_row = up_q ? k_q : '0;
  assign i_c      = up_q ? IW'(32'(j_q) - 32'(d_q)) : IW'(32'(j_q) + 32'(d_q));
  assign r_c      = up_q ? KW'(k_q - d_q) : d_q;

  always_comb begin
    if (up_q) begin
      dmax_c = (32'(j_c) < 32'(k_q)) ? KW'(j_c) : k_q;
    end else begin
      dmax_c = (rest < 32'(k_q)) ? KW'(rest) : k_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (solve_go && (n_cfg != '0)) state_d = S_JRD;
      end
      S_JRD: state_d = S_JCHK;
      S_JCHK: begin
        if (tr_q) begin
          state_d = S_LRD;
        end else if (vec_rd_q == 32'sd0) begin
          state_d = S_JNEXT;
        end else if (unit_q) begin
          state_d = S_LRD;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) state_d = tr_q ? S_JNEXT : S_LRD;
      end
      S_LRD: begin
        if (d_q != '0) begin
          state_d = S_LMUL;
        end else if (tr_q && !unit_q) begin
          state_d = S_DIV;
        end else begin
          state_d = S_JNEXT;
        end
      end
      S_LMUL: state_d = S_LSUB;
      S_LSUB: state_d = S_LRD;
      S_JNEXT: begin
        state_d = (32'(s_q) + 32'd1 == 32'(n_q)) ? S_ORD : S_JRD;
      end
      S_ORD: state_d = S_OLD;
      S_OLD: state_d = S_OWAIT;
      S_OWAIT: begin
        if (!out_stall_i) begin
          state_d = (32'(o_q) + 32'd1 == 32'(n_q)) ? S_IDLE : S_ORD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    vec_re     = 1'b0;
    vec_raddr  = j_c;
    vec_we     = 1'b0;
    vec_waddr  = i_c;
    vec_wdata  = sub_res;
    band_re    = 1'b0;
    band_raddr = BAW'(32'(diag_row) * MAX_ORDER + 32'(j_c));
    band_we    = 1'b0;
    band_waddr = BAW'(32'(in_beat_i.band_row) * MAX_ORDER + 32'(in_beat_i.column));
    div_start  = 1'b0;
    div_num    = vec_rd_q;
    div_den    = band_rd_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (32'(in_beat_i.column) < MAX_ORDER)) begin
          case (in_beat_i.command)
            CMD_BAND: begin
              band_we = (32'(in_beat_i.band_row) <= MAX_BAND);
            end
            CMD_VECTOR: begin
              vec_we    = 1'b1;
              vec_waddr = IW'({26'd0, in_beat_i.column});
              vec_wdata = in_beat_i.value;
            end
            default: ;
          endcase
        end
      end
      S_JRD: begin
        vec_re  = 1'b1;
        band_re = 1'b1;
      end
      S_JCHK: begin
        div_start = !tr_q && (vec_rd_q != 32'sd0) && !unit_q;
      end
      S_DIV: begin
        if (div_done) begin
          vec_we    = 1'b1;
          vec_waddr = j_q;
          vec_wdata = div_quo;
        end
      end
      S_LRD: begin
        vec_raddr  = i_c;
        band_raddr = BAW'(32'(r_c) * MAX_ORDER + 32'(j_q));
        if (d_q != '0) begin
          vec_re  = 1'b1;
          band_re = 1'b1;
        end else if (tr_q) begin
          // transposed: finish the element, by division or directly
          div_num   = t_q;
          div_den   = diag_q;
          div_start = !unit_q;
          vec_we    = unit_q;
          vec_waddr = j_q;
          vec_wdata = t_q;
        end
      end
      S_LSUB: begin
        vec_we = !tr_q;
      end
      S_ORD: begin
        vec_re    = 1'b1;
        vec_raddr = o_q[IW-1:0];
      end
      default: ;
    endcase
  end

  // reads and writes never target the same entry in one cycle: the
  // sequencer runs one access at a time, so no forwarding is needed
  always_ff @(posedge clk_i) begin
    if (vec_we) vec_mem[vec_waddr] <= vec_wdata;
    if (vec_re) vec_rd_q <= vec_mem[vec_raddr];
    if (band_we) band_mem[band_waddr] <= in_beat_i.value;
    if (band_re) band_rd_q <= band_mem[band_raddr];
  end

  bts_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quo_o  (div_quo),
    .dz_o   (div_dz)
  );

  // multiply-subtract path
  assign opa  = tr_q ? vec_rd_q : t_q;
  assign diff = 65'(acc_q) - 65'(prod_q);

  always_comb begin
    if (diff > 65'sh0_7fffffff) begin
      sub_res = 32'sh7fffffff;
    end else if (diff < -65'sh0_80000000) begin
      sub_res = 32'sh80000000;
    end else begin
      sub_res = 32'(diff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      dz_q        <= '0;
      n_q         <= '0;
      k_q         <= '0;
      s_q         <= '0;
      o_q         <= '0;
      d_q         <= '0;
      j_q         <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (solve_go) begin
            n_q  <= n_cfg;
            k_q  <= k_cfg;
            s_q  <= '0;
            o_q  <= '0;
            dz_q <= '0;
          end
        end
        S_JRD: begin
          j_q <= j_c;
          d_q <= dmax_c;
        end
        S_DIV: begin
          if (div_done && div_dz) dz_q[j_q] <= 1'b1;
        end
        S_LSUB: d_q <= d_q - 1'b1;
        S_JNEXT: s_q <= s_q + 1'b1;
        S_OLD: out_valid_q <= 1'b1;
        S_OWAIT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            o_q         <= o_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_JCHK: begin
        t_q    <= vec_rd_q;
        diag_q <= band_rd_q;
      end
      S_DIV: begin
        if (div_done) t_q <= div_quo;
      end
      S_LMUL: begin
        prod_q <= (64'(opa) * 64'(band_rd_q)) >>> FRAC_BITS;
        acc_q  <= tr_q ? t_q : vec_rd_q;
      end
      S_LSUB: begin
        if (tr_q) t_q <= sub_res;
      end
      S_OLD: begin
        out_q.solution       <= vec_rd_q;
        out_q.index          <= 6'(o_q);
        out_q.last           <= (32'(o_q) + 32'd1 == 32'(n_q));
        out_q.divide_by_zero <= dz_q[o_q[IW-1:0]];
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  `BTS_ASSERT_NOW(a_out_only_waiting, out_valid_q, state_q == S_OWAIT, "result beat outside wait")
  `BTS_ASSERT_NOW(a_div_in_div_state, div_busy, state_q == S_DIV, "divider busy outside divide")
  `BTS_ASSERT_NEXT(a_last_ends_solve, out_take && out_q.last, state_q == S_IDLE, "solve not ended")
  `BTS_ASSERT_NOW(a_no_write_on_out, vec_we, !out_valid_q, "vector write during result phase")

endmodule

// ===== rtl/bts_div.sv =====
// iterative signed Q-format divider, one quotient bit per cycle, saturating
// depends on bts_pkg
module bts_div #(
  parameter int FRAC_BITS = bts_pkg::DEF_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               busy_o,
  output logic               done_o,
  output logic signed [31:0] quo_o,
  output logic               dz_o
);
  import bts_pkg::*;

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [31:0]    den_q, den_d;
  logic [31:0]    rem_q, rem_d;
  logic [DW-1:0]  dvd_q, dvd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           neg_q, neg_d;
  logic           zero_q, zero_d;
  logic           npos_q, npos_d;
  logic           nneg_q, nneg_d;
  logic           done_q, done_d;
  logic [32:0]    shifted;
  logic [33:0]    trial;
  logic           ge;
  logic [31:0]    num_mag;
  logic [31:0]    den_mag;
  logic [63:0]    qx;
  logic [63:0]    qneg;

  assign num_mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign den_mag = den_i[31] ? 32'(-den_i) : 32'(den_i);
  assign shifted = {rem_q, dvd_q[DW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};
  assign ge      = !trial[33];

  always_comb begin
    den_d  = den_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    npos_d = npos_q;
    nneg_d = nneg_q;
    done_d = 1'b0;
    if (start_i) begin
      den_d  = den_mag;
      rem_d  = '0;
      dvd_d  = DW'(num_mag) << FRAC_BITS;
      neg_d  = num_i[31] ^ den_i[31];
      npos_d = !num_i[31] && (num_i != 32'sd0);
      nneg_d = num_i[31];
      zero_d = (den_i == 32'sd0);
      if (den_i == 32'sd0) begin
        cnt_d  = '0;
        done_d = 1'b1;
      end else begin
        cnt_d = CW'(DW);
      end
    end else if (cnt_q != '0) begin
      rem_d = ge ? trial[31:0] : shifted[31:0];
      dvd_d = {dvd_q[DW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    npos_q <= npos_d;
    nneg_q <= nneg_d;
  end

  assign qx   = 64'(dvd_q);
  assign qneg = -qx;

  always_comb begin
    if (zero_q) begin
      if (npos_q) begin
        quo_o = 32'sh7fffffff;
      end else if (nneg_q) begin
        quo_o = 32'sh80000000;
      end else begin
        quo_o = 32'sd0;
      end
    end else if (!neg_q) begin
      quo_o = (qx > 64'h7fffffff) ? 32'sh7fffffff : 32'(qx);
    end else begin
      quo_o = (qx > 64'h80000000) ? 32'sh80000000 : 32'(qneg);
    end
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign dz_o   = zero_q;

endmodule

// ===== tb/banded_triangular_solve_test.sv =====
// self-checking testbench for banded_triangular_solve: loads band and vector
// beats, solves under varied register settings, checks every result beat
// depends on bts_pkg and the banded_triangular_solve rtl
module banded_triangular_solve_test;
  import bts_pkg::*;

  localparam int NMAX = DEF_MAX_ORDER;
  localparam int KMAX = DEF_MAX_BAND;
  localparam int FRAC = DEF_FRAC_BITS;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEM_TARGET = 310;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [31:0] Q_ONE = 32'sh00010000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_beat_t in_beat_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_beat_t out_beat_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  banded_triangular_solve i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_beat_i,
    .out_valid_o, .out_stall_i, .out_beat_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic signed [31:0] band_mem [(KMAX+1)*NMAX];
  logic signed [31:0] vec_mem [NMAX];
  bit m_upper = 1'b1, m_trans = 1'b0, m_unit = 1'b0;
  int m_order = 0, m_band = 0;

  // what the stimulus has written so far, to avoid reading undefined entries
  bit band_set [(KMAX+1)*NMAX];
  bit vec_set [NMAX];

  in_beat_t load_q [$];
  out_beat_t solution_q [$];
  int mismatches = 0;
  int gen_items = 0;
  bit calm = 1'b0;
  bit bursty = 1'b1;
  longint cycles = 0;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] mul_sub(logic signed [31:0] acc,
      logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = (longint'(a) * longint'(b)) >>> FRAC;
    return sat32(longint'(acc) - p);
  endfunction

  function automatic logic signed [31:0] quotient(logic signed [31:0] num,
      logic signed [31:0] den);
    if (den == 0) return (num > 0) ? Q_MAX : (num < 0) ? Q_MIN : 32'sd0;
    return sat32((longint'(num) <<< FRAC) / longint'(den));
  endfunction

  function automatic logic signed [31:0] band_at(int r, int c);
    return band_mem[r*NMAX + c];
  endfunction

  function automatic void solve_band();
    int n, k, drow, j, i, lo, hi;
    bit down;
    bit dz [NMAX];
    logic signed [31:0] t;
    out_beat_t r;
    n = (m_order > NMAX) ? NMAX : m_order;
    k = (m_band > KMAX) ? KMAX : m_band;
    drow = m_upper ? k : 0;
    foreach (dz[q]) dz[q] = 1'b0;
    for (int s = 0; s < n; s++) begin
      down = !m_trans ? m_upper : !m_upper;
      j = down ? n - 1 - s : s;
      lo = (j >= k) ? j - k : 0;
      hi = (j + k < n - 1) ? j + k : n - 1;
      if (!m_trans) begin
        if (vec_mem[j] == 0) continue;
        if (!m_unit) begin
          if (band_at(drow, j) == 0) dz[j] = 1'b1;
          vec_mem[j] = quotient(vec_mem[j], band_at(drow, j));
        end
        t = vec_mem[j];
        if (m_upper) begin
          for (i = j; i > lo; i--)
            vec_mem[i-1] = mul_sub(vec_mem[i-1], t, band_at(k + i - 1 - j, j));
        end else begin
          for (i = j + 1; i <= hi; i++)
            vec_mem[i] = mul_sub(vec_mem[i], t, band_at(i - j, j));
        end
      end else begin
        t = vec_mem[j];
        if (m_upper) begin
          for (i = lo; i < j; i++) t = mul_sub(t, band_at(k + i - j, j), vec_mem[i]);
        end else begin
          for (i = hi; i > j; i--) t = mul_sub(t, band_at(i - j, j), vec_mem[i]);
        end
        if (!m_unit) begin
          if (band_at(drow, j) == 0) dz[j] = 1'b1;
          t = quotient(t, band_at(drow, j));
        end
        vec_mem[j] = t;
      end
    end
    for (j = 0; j < n; j++) begin
      r.solution = vec_mem[j];
      r.index = j[5:0];
      r.last = (j == n - 1);
      r.divide_by_zero = dz[j];
      solution_q.push_back(r);
    end
  endfunction

  function automatic void apply_beat(in_beat_t b);
    case (b.command)
      CMD_BAND: if (b.band_row <= KMAX) band_mem[b.band_row*NMAX + b.column] = b.value;
      CMD_VECTOR: vec_mem[b.column] = b.value;
      CMD_SOLVE: solve_band();
      default: ;
    endcase
  endfunction

  // input side: acceptance feeds the predictor
  bit in_took = 1'b0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[banded_triangular_solve] ERROR");
      $finish;
    end
    in_took <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) apply_beat(in_beat_i);
  end

  // result monitor
  always @(posedge clk_i) begin
    out_beat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (solution_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: sol=%0d idx=%0d last=%0b dz=%0b",
                   out_beat_o.solution, out_beat_o.index, out_beat_o.last,
                   out_beat_o.divide_by_zero);
      end else begin
        e = solution_q.pop_front();
        if (out_beat_o.solution !== e.solution || out_beat_o.index !== e.index ||
            out_beat_o.last !== e.last || out_beat_o.divide_by_zero !== e.divide_by_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp sol=%0d idx=%0d last=%0b dz=%0b,",
                      " got sol=%0d idx=%0d last=%0b dz=%0b"},
                     e.solution, e.index, e.last, e.divide_by_zero,
                     out_beat_o.solution, out_beat_o.index, out_beat_o.last,
                     out_beat_o.divide_by_zero);
        end
      end
    end
  end

  // input driver
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (!(in_valid_i && !in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (!calm && bursty && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 4);
        in_valid_i <= 1'b0;
      end else if (load_q.size() > 0) begin
        in_beat_i <= load_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output stall driver; bursty mode flips now and then for idle-free stretches
  int stall_left = 0;
  always @(negedge clk_i) begin
    if ($urandom_range(0, 299) == 0) bursty = !bursty;
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && bursty && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'sd0;
      1: return Q_MAX;
      2: return Q_MIN;
      3: return $urandom;
      default: return $signed($urandom_range(0, 8*65536)) - 4*65536;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_diag();
    case ($urandom_range(0, 11))
      0: return 32'sd0;
      1: return $urandom;
      2: return -Q_ONE;
      default: return $signed($urandom_range(65536, 4*65536));
    endcase
  endfunction

  function automatic void push_beat(logic [1:0] cmd, int row, int col,
      logic signed [31:0] val);
    in_beat_t b;
    b.command = cmd;
    b.band_row = row[3:0];
    b.column = col[5:0];
    b.value = val;
    load_q.push_back(b);
    if (cmd == CMD_BAND && row <= KMAX) band_set[row*NMAX + col] = 1'b1;
    if (cmd == CMD_VECTOR) vec_set[col] = 1'b1;
    if (cmd != CMD_UNUSED && !(cmd == CMD_BAND && row > KMAX)) gen_items++;
  endfunction

  // write whatever the coming solve reads and nobody wrote yet, then solve
  function automatic void push_solve();
    int n, k, rlo, rhi;
    n = (m_order > NMAX) ? NMAX : m_order;
    k = (m_band > KMAX) ? KMAX : m_band;
    for (int j = 0; j < n; j++) begin
      if (!vec_set[j]) push_beat(CMD_VECTOR, 0, j, rand_value());
      rlo = m_upper ? k - ((j < k) ? j : k) : 0;
      rhi = m_upper ? k : ((k < n - 1 - j) ? k : n - 1 - j);
      for (int r = rlo; r <= rhi; r++)
        if (!band_set[r*NMAX + j])
          push_beat(CMD_BAND, r, j, (r == (m_upper ? k : 0)) ? rand_diag() : rand_value());
    end
    push_beat(CMD_SOLVE, $urandom_range(0, 15), $urandom_range(0, 63), $urandom);
  endfunction

  task automatic wait_idle();
    while (load_q.size() > 0 || in_valid_i || solution_q.size() > 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_UPPER: m_upper = val[0];
      REG_TRANS: m_trans = val[0];
      REG_UNIT: m_unit = val[0];
      REG_ORDER: m_order = val & 7'h7f;
      REG_BAND: m_band = val & 4'hf;
      default: ;
    endcase
  endtask

  task automatic set_mode(bit up, bit tr, bit un, int n, int k);
    wait_idle();
    write_reg(REG_UPPER, up);
    write_reg(REG_TRANS, tr);
    write_reg(REG_UNIT, un);
    write_reg(REG_ORDER, n);
    write_reg(REG_BAND, k);
  endtask

  initial begin
    int n, k, nn, kk;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero diagonal, zero right-hand element, extremes, ignored beats
    set_mode(1'b1, 1'b0, 1'b0, 3, 1);
    push_beat(CMD_BAND, 1, 0, Q_ONE);
    push_beat(CMD_BAND, 1, 1, 32'sd0);
    push_beat(CMD_BAND, 1, 2, Q_MAX);
    push_beat(CMD_BAND, 0, 1, Q_MIN);
    push_beat(CMD_BAND, 0, 2, 32'sh00018000);
    push_beat(CMD_VECTOR, 15, 0, Q_MAX);
    push_beat(CMD_VECTOR, 0, 1, Q_MIN);
    push_beat(CMD_VECTOR, 0, 2, 32'sd0);
    push_beat(CMD_UNUSED, 15, 63, 32'shffffffff);
    push_beat(CMD_BAND, 15, 63, Q_MAX);
    push_solve();
    push_beat(CMD_VECTOR, 0, 1, -Q_ONE);
    push_beat(CMD_VECTOR, 0, 2, 32'sh00030000);
    push_solve();
    set_mode(1'b0, 1'b1, 1'b1, 3, 1);
    push_solve();
    set_mode(1'b0, 1'b0, 1'b0, 0, 15);
    push_solve();
    // order above the store depth, then band wider than the maximum
    set_mode(1'b1, 1'b1, 1'b0, 127, 0);
    push_solve();
    set_mode(1'b1, 1'b1, 1'b0, 3, 15);
    push_solve();
    set_mode(1'b0, 1'b0, 1'b1, 64, 0);
    push_solve();

    // random phases of well-formed load and solve sequences, with some noise
    while (gen_items < ITEM_TARGET) begin
      if (gen_items > ITEM_TARGET * 4 / 5) calm = 1'b1;
      case ($urandom_range(0, 11))
        0: n = 0;
        1: n = $urandom_range(64, 127);
        2: n = $urandom_range(9, 63);
        default: n = $urandom_range(1, 8);
      endcase
      k = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      nn = (n > NMAX) ? NMAX : n;
      kk = (k > KMAX) ? KMAX : k;
      // large phases only while the beat budget has room for them
      if (gen_items + nn * (kk + 4) + 20 > ITEM_TARGET) begin
        n = $urandom_range(1, 4);
        k = $urandom_range(0, 2);
        nn = n;
      end
      set_mode($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1), n, k);
      repeat ($urandom_range(1, 3)) begin
        for (int j = 0; j < nn; j++)
          if ($urandom_range(0, 2) != 0) push_beat(CMD_VECTOR, $urandom_range(0, 15), j,
                                                   rand_value());
        repeat ($urandom_range(0, 4)) begin
          if (nn > 0) push_beat(CMD_BAND, $urandom_range(0, (k > KMAX) ? KMAX : k),
                                $urandom_range(0, nn - 1), rand_diag());
        end
        if ($urandom_range(0, 3) == 0)
          push_beat(CMD_UNUSED, $urandom_range(0, 15), $urandom_range(0, 63), $urandom);
        if ($urandom_range(0, 3) == 0)
          push_beat(CMD_BAND, $urandom_range(9, 15), $urandom_range(0, 63), $urandom);
        push_solve();
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("[banded_triangular_solve] OK");
    end else begin
      $display("[banded_triangular_solve] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bts_pkg.sv
rtl/bts_div.sv
rtl/banded_triangular_solve.sv
tb/banded_triangular_solve_test.sv
